// File: src/fpsr_pkg.sv
package fpsr_pkg;

   // Width of the signed radicand; the sign is its top bit
   localparam int RADICAND_BITS = 32;
   // Width of the fraction bit count field
   localparam int FRAC_WIDTH    = 5;
   localparam int FRAC_MAX      = (1 << FRAC_WIDTH) - 1;
   // Width of the result root field
   localparam int ROOT_WIDTH    = 31;
   localparam logic [FRAC_WIDTH-1:0] FRAC_RESET = FRAC_WIDTH'(16);

   // Magnitude bits shifted up by the largest fraction count
   localparam int SCALED_BITS   = RADICAND_BITS - 1 + FRAC_MAX;
   // One root digit per pair of scaled radicand bits
   localparam int STEPS         = (SCALED_BITS + 1) / 2;
   localparam int RAD_BITS      = 2 * STEPS;
   localparam int REM_BITS      = STEPS + 2;

   typedef struct packed {
      logic                neg;
      logic [RAD_BITS-1:0] rad;
      logic [REM_BITS-1:0] rem;
      logic [STEPS-1:0]    root;
   } stage_type;

   typedef struct packed {
      logic [ROOT_WIDTH-1:0] root;
      logic                  negative_error;
   } result_type;

endpackage

// File: src/fpsr_digit_stage.sv
module fpsr_digit_stage
   import fpsr_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      advance,
   input  logic      prev_valid,
   input  stage_type prev,
   output logic      this_valid,
   output stage_type this_stage
);

   logic                valid_ff;
   stage_type           data_ff;
   stage_type           data_in;
   logic [REM_BITS-1:0] rem_shift;
   logic [REM_BITS-1:0] trial;
   logic [REM_BITS:0]   diff;

   // One restoring root digit: bring down two bits, try root*4+1
   always_comb begin
      rem_shift = {prev.rem[STEPS-1:0], prev.rad[RAD_BITS-1 -: 2]};
      trial     = {prev.root, 2'b01};
      diff      = {1'b0, rem_shift} - {1'b0, trial};
      data_in.neg = prev.neg;
      data_in.rad = {prev.rad[RAD_BITS-3:0], 2'b00};
      if (!diff[REM_BITS]) begin
         data_in.rem  = diff[REM_BITS-1:0];
         data_in.root = {prev.root[STEPS-2:0], 1'b1};
      end else begin
         data_in.rem  = rem_shift;
         data_in.root = {prev.root[STEPS-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= prev_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign this_valid = valid_ff;
   assign this_stage = data_ff;

endmodule

// File: src/fixed_point_square_root.sv
// channel   direction  ports                                   handshake
// request   in         req_radicand                            req_valid / req_stall
// response  out        rsp_root, rsp_negative_error            rsp_valid / rsp_stall
// csr       in         csr_write_data (frac_bits)              csr_write_enable
//
// A request enters every cycle while req_stall is low; each result passes through
// an entry register that scales it, one register stage per root digit and one output
// register. Throughput is one request per cycle while req_stall is low.
// Reset clears all valid bits and loads frac_bits with 16.
// A stalled response parks a second result in a skid register; only then is
// req_stall raised and the whole pipeline held, so nothing is lost or repeated.
module fixed_point_square_root
   import fpsr_pkg::*;
(
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic signed [RADICAND_BITS-1:0] req_radicand,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [ROOT_WIDTH-1:0]           rsp_root,
   output logic                            rsp_negative_error,
   input  logic                            csr_write_enable,
   input  logic [FRAC_WIDTH-1:0]           csr_write_data
);

   logic [FRAC_WIDTH-1:0] frac_bits_ff;
   logic                  advance;
   logic                  pop;
   logic                  stage_valid [0:STEPS];
   stage_type             stage_data  [0:STEPS];
   logic                  entry_valid_ff;
   stage_type             entry_ff;
   stage_type             entry_in;
   result_type            arriving;
   result_type            out_ff;
   result_type            skid_ff;
   logic                  out_valid_ff;
   logic                  skid_valid_ff;

   // Configuration: only the fraction count, to be written while idle; the block does not enforce this
   always_ff @(posedge clock) begin
      if (reset) begin
         frac_bits_ff <= FRAC_RESET;
      end else if (csr_write_enable) begin
         frac_bits_ff <= csr_write_data;
      end
   end

   // Hold the pipeline only once the skid register is occupied
   assign advance   = !skid_valid_ff;
   assign req_stall = skid_valid_ff;
   assign pop       = out_valid_ff && !rsp_stall;

   // Entry stage: drop the sign bit and scale the magnitude by 2^frac_bits
   always_comb begin
      entry_in.neg  = req_radicand[RADICAND_BITS-1];
      entry_in.rad  = RAD_BITS'(req_radicand[RADICAND_BITS-2:0]) << frac_bits_ff;
      entry_in.rem  = '0;
      entry_in.root = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= 1'b0;
      end else if (advance) begin
         entry_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         entry_ff <= entry_in;
      end
   end

   assign stage_valid[0] = entry_valid_ff;
   assign stage_data[0]  = entry_ff;

   // One register stage per root digit, most significant digit first
   for (genvar g = 1; g <= STEPS; g++) begin : g_digit
      fpsr_digit_stage u_stage (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance),
         .prev_valid (stage_valid[g-1]),
         .prev       (stage_data[g-1]),
         .this_valid (stage_valid[g]),
         .this_stage (stage_data[g])
      );
   end

   // Force a zero root for a negative radicand
   always_comb begin
      arriving.negative_error = stage_data[STEPS].neg;
      arriving.root = stage_data[STEPS].neg ? '0 : ROOT_WIDTH'(stage_data[STEPS].root);
   end

   // Output register plus skid: a finished result blocks new requests only once the skid is occupied
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (!out_valid_ff || pop) begin
         out_valid_ff <= stage_valid[STEPS];
      end else if (stage_valid[STEPS]) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            out_ff <= skid_ff;
         end
      end else if (!out_valid_ff || pop) begin
         out_ff <= arriving;
      end else begin
         skid_ff <= arriving;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_root           = out_ff.root;
   assign rsp_negative_error = out_ff.negative_error;

   // The skid register only ever backs up an occupied output register
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid holds a result while the output register is empty");

   // A result enters the skid only when the output was stalled
   assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(out_valid_ff && rsp_stall))
      else $error("skid filled without a stalled response");

   // A parked result stays parked until the response side takes one
   assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && rsp_stall) |=> skid_valid_ff)
      else $error("skid result lost under stall");

   // An error result carries a zero root
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_negative_error) |-> (rsp_root == '0))
      else $error("negative radicand returned a non-zero root");

endmodule
